// File: src/isort_pkg.sv
package isort_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef struct packed {
        logic capture;
        logic drop;
        logic shift;
        logic place;
        logic emit_sel;
        logic emit_load;
        logic run_clear;
    } isort_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic greater;
        logic k_one;
        logic final_elem;
        logic out_free;
    } isort_status_t;

endpackage

// File: src/isort_ram.sv
module isort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/isort_ctrl.sv
module isort_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   last,
    input  isort_pkg::isort_status_t status,
    output isort_pkg::isort_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CMP     = 3'd1;
    localparam logic [2:0] S_PLACE   = 3'd2;
    localparam logic [2:0] S_EMIT_RD = 3'd3;
    localparam logic [2:0] S_EMIT_LD = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       last_item_reg;
    logic       last_item_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        last_item_next = last_item_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    last_item_next = last;
                    if (status.full)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = last ? S_EMIT_RD : S_IDLE;
                    end
                    else if (status.empty)
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        state_next = S_CMP;
                    end
                end
            end
            S_CMP:
            begin
                if (status.greater)
                begin
                    cmd.shift  = 1'b1;
                    state_next = status.k_one ? S_PLACE : S_CMP;
                end
                else
                begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = last_item_reg ? S_EMIT_RD : S_IDLE;
            end
            S_EMIT_RD:
            begin
                cmd.emit_sel = 1'b1;
                state_next   = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                cmd.emit_sel = 1'b1;
                if (status.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    if (status.final_elem)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_item_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_item_reg <= last_item_next;
        end
    end

endmodule

// File: src/isort_dp.sv
module isort_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [isort_pkg::DATA_W-1:0]  value,
    input  isort_pkg::isort_cmd_t                cmd,
    output isort_pkg::isort_status_t             status,
    output logic signed [isort_pkg::DATA_W-1:0]  sorted_value,
    output logic                                 last_res,
    output logic                                 overflow,
    output logic                                 out_valid,
    input  logic                                 out_ready
);

    logic signed [isort_pkg::DATA_W-1:0] value_reg;
    logic [isort_pkg::IDX_W-1:0]         k_reg;
    logic [isort_pkg::IDX_W-1:0]         k_next;
    logic [isort_pkg::IDX_W-1:0]         i_reg;
    logic [isort_pkg::CNT_W-1:0]         count_reg;
    logic                                dropped_reg;
    logic                                out_valid_reg;
    logic signed [isort_pkg::DATA_W-1:0] sorted_value_reg;
    logic                                last_res_reg;
    logic                                overflow_reg;

    logic                                we;
    logic [isort_pkg::IDX_W-1:0]         raddr;
    logic [isort_pkg::DATA_W-1:0]        wdata;
    logic [isort_pkg::DATA_W-1:0]        rdata;

    always_comb
    begin
        if (cmd.capture)
        begin
            k_next = count_reg[isort_pkg::IDX_W-1:0];
        end
        else if (cmd.shift)
        begin
            k_next = k_reg - isort_pkg::IDX_W'(1);
        end
        else
        begin
            k_next = k_reg;
        end
    end

    assign raddr = cmd.emit_sel ? i_reg : (k_next - isort_pkg::IDX_W'(1));
    assign we    = cmd.shift | cmd.place;
    assign wdata = cmd.shift ? rdata : value_reg;

    isort_ram #(
        .WIDTH (isort_pkg::DATA_W),
        .DEPTH (isort_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (k_reg),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.full       = (count_reg == isort_pkg::CNT_W'(isort_pkg::CAPACITY));
    assign status.empty      = (count_reg == '0);
    assign status.greater    = ($signed(rdata) > value_reg);
    assign status.k_one      = (k_reg == isort_pkg::IDX_W'(1));
    assign status.final_elem = (isort_pkg::CNT_W'(i_reg) == count_reg - isort_pkg::CNT_W'(1));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= value;
        end
        k_reg <= k_next;
        if (cmd.emit_load)
        begin
            sorted_value_reg <= $signed(rdata);
            last_res_reg     <= status.final_elem;
            overflow_reg     <= dropped_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.run_clear)
            begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
                i_reg       <= '0;
            end
            else
            begin
                if (cmd.place)
                begin
                    count_reg <= count_reg + isort_pkg::CNT_W'(1);
                end
                if (cmd.drop)
                begin
                    dropped_reg <= 1'b1;
                end
                if (cmd.emit_load)
                begin
                    i_reg <= i_reg + isort_pkg::IDX_W'(1);
                end
            end
            if (cmd.emit_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sorted_value = sorted_value_reg;
    assign last_res     = last_res_reg;
    assign overflow     = overflow_reg;
    assign out_valid    = out_valid_reg;

endmodule

// File: src/insertion_sorter.sv
// Insertion sorter for runs of signed 32-bit values, one value per item, the run's
// last item marked by last. Values live in a single-port-write, registered-read RAM of
// CAPACITY entries; equal values keep their arrival order. Inserting a value into an
// empty store goes straight to the place step; otherwise each stored value greater than
// the new one is shifted up one slot, one RAM read and one RAM write per step, before
// the new value is placed. A value arriving to a full store is dropped and sets overflow
// on every result of that run. After the last item the store is read out in ascending
// order, one RAM read and then one output load per result, waiting while the output is
// stalled, last_res on the final one; no new item is taken until the read-out is done.
module insertion_sorter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [isort_pkg::DATA_W-1:0] value,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
    output logic                                last_res,
    output logic                                overflow
);

    isort_pkg::isort_cmd_t    cmd;
    isort_pkg::isort_status_t status;

    isort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .last     (last),
        .status   (status),
        .cmd      (cmd)
    );

    isort_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .sorted_value (sorted_value),
        .last_res     (last_res),
        .overflow     (overflow),
        .out_valid    (out_valid),
        .out_ready    (out_ready)
    );

endmodule
